[sv/clcd_pkg.sv]
package clcd_pkg;

    // timer width default
    localparam int TIMER_BITS_DEF = 16;

    // one millisecond in microsecond ticks
    localparam logic [15:0] TICKS_PER_MS = 16'd1000;

    // configuration register indexes
    localparam logic [2:0] REG_TWO_LINES = 3'd0;
    localparam logic [2:0] REG_TALL_FONT = 3'd1;
    localparam logic [2:0] REG_CURSOR_ON = 3'd2;
    localparam logic [2:0] REG_BLINK     = 3'd3;
    localparam logic [2:0] REG_CMD_PULSE = 3'd4;
    localparam logic [2:0] REG_DAT_PULSE = 3'd5;

    // configuration reset values
    localparam logic [15:0] CMD_PULSE_RST = 16'd5000;
    localparam logic [15:0] DAT_PULSE_RST = 16'd40;

    // request operation codes
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_INIT   = 3'd1,
        OP_CMD    = 3'd2,
        OP_CHAR   = 3'd3,
        OP_POS    = 3'd4,
        OP_SHIFT  = 3'd5,
        OP_CGADDR = 3'd6,
        OP_RSVD   = 3'd7
    } t_op;

    // configuration seen by the sequencer
    typedef struct packed {
        logic        two_lines;
        logic        tall_font;
        logic        cursor_on;
        logic        blink_bit;
        logic [15:0] command_pulse_us;
        logic [15:0] data_pulse_us;
    } t_cfg;

    // pin levels and status after one request
    typedef struct packed {
        logic [3:0] data_nibble;
        logic       reg_select;
        logic       enable_pin;
        logic       busy_res;
        logic       rejected;
    } t_res;

endpackage

[sv/clcd_seq_core.sv]
module clcd_seq_core #(
    parameter int TIMER_BITS = clcd_pkg::TIMER_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [2:0]         i_operation,
    input  logic [7:0]         i_value,
    input  logic [4:0]         i_column,
    input  logic [1:0]         i_line,
    input  clcd_pkg::t_cfg     i_cfg,
    output clcd_pkg::t_res     o_res
);

    typedef enum logic [1:0] {
        K_NONE,
        K_NIB,
        K_WAIT
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] nib;
        logic       sel;
        logic [5:0] ms;
    } t_step;

    // what a given step of the active request does
    function automatic t_step step_decode(input clcd_pkg::t_op act, input logic [4:0] step,
                                          input logic [7:0] lb, input clcd_pkg::t_cfg cfg);
        t_step d;
        d.kind = K_NONE;
        d.nib  = 4'd0;
        d.sel  = 1'b0;
        d.ms   = 6'd0;
        unique case (act)
            clcd_pkg::OP_INIT: begin
                unique case (step)
                    5'd1:  begin d.kind = K_WAIT; d.ms = 6'd40; end
                    5'd2:  begin d.kind = K_NIB;  d.nib = 4'h3; end
                    5'd3:  begin d.kind = K_WAIT; d.ms = 6'd5; end
                    5'd4:  begin d.kind = K_NIB;  d.nib = 4'h3; end
                    5'd5:  begin d.kind = K_WAIT; d.ms = 6'd1; end
                    5'd6:  begin d.kind = K_NIB;  d.nib = 4'h3; end
                    5'd7:  begin d.kind = K_WAIT; d.ms = 6'd1; end
                    5'd8:  begin d.kind = K_NIB;  d.nib = 4'h2; end
                    5'd9:  begin d.kind = K_WAIT; d.ms = 6'd1; end
                    5'd10: begin d.kind = K_NIB;  d.nib = 4'h2; end
                    5'd11: begin
                        d.kind = K_NIB;
                        d.nib  = {cfg.two_lines, cfg.tall_font, 2'b00};
                    end
                    5'd12: begin d.kind = K_NIB;  d.nib = 4'h0; end
                    5'd13: begin d.kind = K_NIB;  d.nib = 4'h8; end
                    5'd14: begin d.kind = K_NIB;  d.nib = 4'h0; end
                    5'd15: begin d.kind = K_NIB;  d.nib = 4'h1; end
                    5'd16: begin d.kind = K_WAIT; d.ms = 6'd5; end
                    5'd17: begin d.kind = K_NIB;  d.nib = 4'h0; end
                    5'd18: begin d.kind = K_NIB;  d.nib = 4'h6; end
                    5'd19: begin d.kind = K_WAIT; d.ms = 6'd20; end
                    5'd20: begin d.kind = K_NIB;  d.nib = 4'h0; end
                    5'd21: begin
                        d.kind = K_NIB;
                        d.nib  = {2'b11, cfg.cursor_on, cfg.blink_bit};
                    end
                    5'd22: begin d.kind = K_WAIT; d.ms = 6'd20; end
                    default: d.kind = K_NONE;
                endcase
            end
            clcd_pkg::OP_CMD: begin
                if (step == 5'd1) begin
                    d.kind = K_NIB;
                    d.nib  = lb[3:0];
                end
            end
            clcd_pkg::OP_CHAR, clcd_pkg::OP_POS, clcd_pkg::OP_SHIFT,
            clcd_pkg::OP_CGADDR: begin
                d.sel = (act == clcd_pkg::OP_CHAR);
                if (step == 5'd1) begin
                    d.kind = K_NIB;
                    d.nib  = lb[7:4];
                end else if (step == 5'd2) begin
                    d.kind = K_NIB;
                    d.nib  = lb[3:0];
                end
            end
            default: d.kind = K_NONE;
        endcase
        if (step == 5'd0) begin
            d.kind = K_NONE;
        end
        return d;
    endfunction

    // timer load for a starting step, never zero
    function automatic logic [TIMER_BITS-1:0] step_load(input t_step d,
                                                      input clcd_pkg::t_cfg cfg);
        logic [15:0]           ticks;
        logic [15:0]           pulse;
        logic [TIMER_BITS-1:0] ld;
        ticks = 16'({10'd0, d.ms}) * clcd_pkg::TICKS_PER_MS;
        pulse = d.sel ? cfg.data_pulse_us : cfg.command_pulse_us;
        if (d.kind == K_WAIT) begin
            ld = TIMER_BITS'(ticks);
        end else begin
            ld = TIMER_BITS'(pulse);
        end
        if (ld == '0) begin
            ld = TIMER_BITS'(1);
        end
        return ld;
    endfunction

    clcd_pkg::t_op         op;
    logic [4:0]            r_step, n_step;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    clcd_pkg::t_op         r_active, n_active;
    logic [7:0]            r_latched, n_latched;
    logic [3:0]            r_pin_data, n_pin_data;
    logic                  r_pin_sel, n_pin_sel;
    logic                  r_pin_en, n_pin_en;
    logic                  n_rej;
    logic                  bad_pos;
    logic [7:0]            req_byte;
    logic [4:0]            step_inc;
    logic [TIMER_BITS-1:0] timer_dec;
    t_step                 cur_d, nxt_d, req_d;

    assign op       = clcd_pkg::t_op'(i_operation);
    assign bad_pos  = (i_column < 5'd1) || (i_column > 5'd16)
                   || (i_line < 2'd1) || (i_line > 2'd2);
    assign step_inc = r_step + 5'd1;
    assign timer_dec = r_timer - 1'b1;

    // byte latched for a new request
    always_comb begin
        unique case (op)
            clcd_pkg::OP_CMD:    req_byte = {4'h0, i_value[3:0]};
            clcd_pkg::OP_CHAR:   req_byte = i_value;
            clcd_pkg::OP_POS:    req_byte = ((i_line == 2'd1) ? 8'h80 : 8'hC0)
                                          + {3'd0, i_column} - 8'd1;
            clcd_pkg::OP_SHIFT:  req_byte = {4'h1, i_value[3:0]};
            clcd_pkg::OP_CGADDR: req_byte = {2'b01, i_value[5:0]};
            default:             req_byte = 8'h00;
        endcase
    end

    assign cur_d = step_decode(r_active, r_step, r_latched, i_cfg);
    assign nxt_d = step_decode(r_active, step_inc, r_latched, i_cfg);
    assign req_d = step_decode(op, 5'd1, req_byte, i_cfg);

    // next state for one request
    always_comb begin
        n_step     = r_step;
        n_timer    = r_timer;
        n_active   = r_active;
        n_latched  = r_latched;
        n_pin_data = r_pin_data;
        n_pin_sel  = r_pin_sel;
        n_pin_en   = r_pin_en;
        n_rej      = 1'b0;
        if (i_fire) begin
            priority if (op == clcd_pkg::OP_TICK) begin
                if (r_step != 5'd0) begin
                    if (r_timer != '0) begin
                        // count down, finish the step at zero
                        n_timer = timer_dec;
                        if (timer_dec == '0) begin
                            if (cur_d.kind == K_NIB) begin
                                n_pin_en = 1'b0;
                            end
                            n_step = (nxt_d.kind == K_NONE) ? 5'd0 : step_inc;
                        end
                    end else if (cur_d.kind == K_NONE) begin
                        n_step  = 5'd0;
                        n_timer = '0;
                    end else begin
                        // start the current step
                        if (cur_d.kind == K_NIB) begin
                            n_pin_data = cur_d.nib;
                            n_pin_sel  = cur_d.sel;
                            n_pin_en   = 1'b1;
                        end
                        n_timer = step_load(cur_d, i_cfg);
                    end
                end
            end else if (op == clcd_pkg::OP_RSVD || r_step != 5'd0
                         || (op == clcd_pkg::OP_POS && bad_pos)) begin
                n_rej = 1'b1;
            end else begin
                // accept the request and start step one
                n_latched = req_byte;
                n_active  = op;
                n_step    = 5'd1;
                if (req_d.kind == K_NIB) begin
                    n_pin_data = req_d.nib;
                    n_pin_sel  = req_d.sel;
                    n_pin_en   = 1'b1;
                end else begin
                    n_pin_data = 4'h0;
                    n_pin_sel  = 1'b0;
                    n_pin_en   = 1'b0;
                end
                n_timer = step_load(req_d, i_cfg);
            end
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= 5'd0;
            r_timer    <= '0;
            r_active   <= clcd_pkg::OP_TICK;
            r_latched  <= 8'h00;
            r_pin_data <= 4'h0;
            r_pin_sel  <= 1'b0;
            r_pin_en   <= 1'b0;
        end else begin
            r_step     <= n_step;
            r_timer    <= n_timer;
            r_active   <= n_active;
            r_latched  <= n_latched;
            r_pin_data <= n_pin_data;
            r_pin_sel  <= n_pin_sel;
            r_pin_en   <= n_pin_en;
        end
    end

    assign o_res.data_nibble = n_pin_data;
    assign o_res.reg_select  = n_pin_sel;
    assign o_res.enable_pin  = n_pin_en;
    assign o_res.busy_res    = (n_step != 5'd0);
    assign o_res.rejected    = n_rej;

    // enable only pulses inside a sequence
    a_en_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pin_en |-> (r_step != 5'd0))
        else $error("enable high while idle");

    // a running timer belongs to a sequence
    a_timer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_timer != '0) |-> (r_step != 5'd0))
        else $error("timer running while idle");

    // a refused request leaves the sequence alone
    a_rej_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && n_rej) |=> (r_step == $past(r_step) && r_timer == $past(r_timer)))
        else $error("refused request changed the sequence");

    // an accepted request starts at step one
    a_req_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && op != clcd_pkg::OP_TICK && !n_rej)
        |=> (r_step == 5'd1 && r_active == $past(op) && r_timer != '0))
        else $error("accepted request did not start");

endmodule

[sv/char_lcd_nibble_interface_sequencer.sv]
// channel   direction  handshake                   payload
// request   in         i_in_valid / o_in_ready     i_operation i_value i_column i_line
// result    out        o_out_valid / i_out_ready   o_data_nibble o_reg_select o_enable_pin
//                                                  o_busy_res o_rejected
// config    in         i_cfg_we (no wait)          i_cfg_index i_cfg_data
//
// One request per clock while results are drained: the sequencer state updates in the cycle a
// request is taken and the result lands in the output register on that edge.
// A new request is taken whenever the output register is empty or being drained.
// A stalled result holds the output register; the sequencer itself never waits.
// Reset is synchronous and active low; the sequencer is idle with its pins low after it (the output
// register is not reset), and configuration returns to 5000 us command and 40 us data enable pulses.
module char_lcd_nibble_interface_sequencer #(
    parameter int TIMER_BITS = clcd_pkg::TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_value,
    input  logic [4:0]  i_column,
    input  logic [1:0]  i_line,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_data_nibble,
    output logic        o_reg_select,
    output logic        o_enable_pin,
    output logic        o_busy_res,
    output logic        o_rejected
);

    clcd_pkg::t_cfg r_cfg;
    clcd_pkg::t_res n_res;
    clcd_pkg::t_res r_res;
    logic           r_out_valid;
    logic           fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.two_lines        <= 1'b0;
            r_cfg.tall_font        <= 1'b0;
            r_cfg.cursor_on        <= 1'b0;
            r_cfg.blink_bit        <= 1'b0;
            r_cfg.command_pulse_us <= clcd_pkg::CMD_PULSE_RST;
            r_cfg.data_pulse_us    <= clcd_pkg::DAT_PULSE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                clcd_pkg::REG_TWO_LINES: r_cfg.two_lines        <= i_cfg_data[0];
                clcd_pkg::REG_TALL_FONT: r_cfg.tall_font        <= i_cfg_data[0];
                clcd_pkg::REG_CURSOR_ON: r_cfg.cursor_on        <= i_cfg_data[0];
                clcd_pkg::REG_BLINK:     r_cfg.blink_bit        <= i_cfg_data[0];
                clcd_pkg::REG_CMD_PULSE: r_cfg.command_pulse_us <= i_cfg_data;
                clcd_pkg::REG_DAT_PULSE: r_cfg.data_pulse_us    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    clcd_seq_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_column    (i_column),
        .i_line      (i_line),
        .i_cfg       (r_cfg),
        .o_res       (n_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_nibble = r_res.data_nibble;
    assign o_reg_select  = r_res.reg_select;
    assign o_enable_pin  = r_res.enable_pin;
    assign o_busy_res    = r_res.busy_res;
    assign o_rejected    = r_res.rejected;

endmodule

[test/clcd_sequencer_checker.sv]
module clcd_sequencer_checker
    import clcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_value,
    input  logic [4:0]  i_column,
    input  logic [1:0]  i_line,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [3:0]  i_data_nibble,
    input  logic        i_reg_select,
    input  logic        i_enable_pin,
    input  logic        i_busy_res,
    input  logic        i_rejected,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_seq_busy
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_NIBBLE,
        STEP_WAIT
    } step_kind_e;

    // shadow of the configuration registers
    logic        cfg_two_lines = 1'b0;
    logic        cfg_tall_font = 1'b0;
    logic        cfg_cursor_on = 1'b0;
    logic        cfg_blink     = 1'b0;
    logic [15:0] cfg_cmd_pulse = CMD_PULSE_RST;
    logic [15:0] cfg_dat_pulse = DAT_PULSE_RST;

    // shadow of the bus sequencer
    logic [4:0]  seq_step  = '0;
    logic [15:0] seq_timer = '0;
    t_op         seq_op    = OP_TICK;
    logic [7:0]  seq_byte  = '0;
    logic [3:0]  pin_nib   = '0;
    logic        pin_rs    = 1'b0;
    logic        pin_en    = 1'b0;

    // pin levels still owed by the block, oldest first
    t_res lcd_expect_q[$];
    int   err_total = 0;

    // a zero enable width behaves as one tick
    function automatic logic [15:0] enable_width(input logic [15:0] w);
        return (w == 16'd0) ? 16'd1 : w;
    endfunction

    // what step idx of the running request does
    function automatic step_kind_e decode_step(input logic [4:0] idx, output logic [3:0] nib,
                                               output logic rs, output logic [15:0] load);
        step_kind_e kind;
        int         ms;
        int         n_nibbles;
        nib = 4'h0;
        rs = 1'b0;
        load = 16'd0;
        ms = 0;
        kind = STEP_NIBBLE;
        if (idx == 5'd0) begin
            kind = STEP_NONE;
        end else if (seq_op == OP_INIT) begin
            // power-up program
            case (idx)
                5'd1:                      ms = 40;
                5'd2, 5'd4, 5'd6:          nib = 4'h3;
                5'd3, 5'd16:               ms = 5;
                5'd5, 5'd7, 5'd9:          ms = 1;
                5'd8, 5'd10:               nib = 4'h2;
                5'd11:                     nib = {cfg_two_lines, cfg_tall_font, 2'b00};
                5'd12, 5'd14, 5'd17, 5'd20: nib = 4'h0;
                5'd13:                     nib = 4'h8;
                5'd15:                     nib = 4'h1;
                5'd18:                     nib = 4'h6;
                5'd19, 5'd22:              ms = 20;
                5'd21:                     nib = {2'b11, cfg_cursor_on, cfg_blink};
                default:                   kind = STEP_NONE;
            endcase
            if (ms != 0) begin
                kind = STEP_WAIT;
                load = 16'(ms * TICKS_PER_MS);
            end else begin
                load = enable_width(cfg_cmd_pulse);
            end
        end else if (seq_op >= OP_CMD && seq_op <= OP_CGADDR) begin
            // one or two nibbles, high first
            n_nibbles = (seq_op == OP_CMD) ? 1 : 2;
            if (int'(idx) > n_nibbles) begin
                kind = STEP_NONE;
            end else begin
                nib = (n_nibbles == 1 || idx == 5'd2) ? seq_byte[3:0] : seq_byte[7:4];
                rs = (seq_op == OP_CHAR);
                load = enable_width(rs ? cfg_dat_pulse : cfg_cmd_pulse);
            end
        end else begin
            kind = STEP_NONE;
        end
        if (kind == STEP_NONE) begin
            nib = 4'h0;
            rs = 1'b0;
            load = 16'd0;
        end
        return kind;
    endfunction

    // launch the current step
    task automatic begin_step();
        logic [3:0]  nib;
        logic        rs;
        logic [15:0] load;
        step_kind_e  kind;
        kind = decode_step(seq_step, nib, rs, load);
        if (kind == STEP_NONE) begin
            seq_step = 5'd0;
            seq_timer = 16'd0;
        end else begin
            if (kind == STEP_NIBBLE) begin
                pin_nib = nib;
                pin_rs = rs;
                pin_en = 1'b1;
            end
            seq_timer = load;
        end
    endtask

    // one microsecond tick
    task automatic tick_sequencer();
        logic [3:0]  nib;
        logic        rs;
        logic [15:0] load;
        if (seq_step == 5'd0)
            return;
        if (seq_timer != 16'd0) begin
            seq_timer = seq_timer - 16'd1;
            if (seq_timer == 16'd0) begin
                if (decode_step(seq_step, nib, rs, load) == STEP_NIBBLE)
                    pin_en = 1'b0;
                seq_step = seq_step + 5'd1;
                if (decode_step(seq_step, nib, rs, load) == STEP_NONE)
                    seq_step = 5'd0;
            end
        end else begin
            begin_step();
        end
    endtask

    // apply one request and give the pin levels after it
    task automatic step_lcd_bus(input t_op op, input logic [7:0] val, input logic [4:0] col,
                                input logic [1:0] ln, output t_res r);
        logic refused;
        refused = 1'b0;
        if (op == OP_TICK) begin
            tick_sequencer();
        end else if (op == OP_RSVD || seq_step != 5'd0) begin
            refused = 1'b1;
        end else if (op == OP_POS && (col < 5'd1 || col > 5'd16 || ln < 2'd1 || ln > 2'd2)) begin
            refused = 1'b1;
        end else begin
            case (op)
                OP_INIT:  seq_byte = 8'h00;
                OP_CMD:   seq_byte = {4'h0, val[3:0]};
                OP_CHAR:  seq_byte = val;
                OP_POS:   seq_byte = ((ln == 2'd1) ? 8'h80 : 8'hC0) + 8'(col) - 8'd1;
                OP_SHIFT: seq_byte = {4'h1, val[3:0]};
                default:  seq_byte = {2'b01, val[5:0]};
            endcase
            seq_op = op;
            if (op == OP_INIT) begin
                pin_nib = 4'h0;
                pin_rs = 1'b0;
                pin_en = 1'b0;
            end
            seq_step = 5'd1;
            begin_step();
        end
        r = {pin_nib, pin_rs, pin_en, (seq_step != 5'd0), refused};
    endtask

    task automatic apply_register(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            REG_TWO_LINES: cfg_two_lines = data[0];
            REG_TALL_FONT: cfg_tall_font = data[0];
            REG_CURSOR_ON: cfg_cursor_on = data[0];
            REG_BLINK:     cfg_blink = data[0];
            REG_CMD_PULSE: cfg_cmd_pulse = data;
            REG_DAT_PULSE: cfg_dat_pulse = data;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns lcd bus mismatch: %s", $time, what);
        err_total++;
    endtask

    // field by field against the oldest expectation
    task automatic compare_result(input t_res got);
        t_res want;
        if (lcd_expect_q.size() == 0) begin
            report_mismatch("result with no request outstanding");
            return;
        end
        want = lcd_expect_q.pop_front();
        if (got.data_nibble !== want.data_nibble)
            report_mismatch($sformatf("data_nibble %h, expected %h",
                                      got.data_nibble, want.data_nibble));
        if (got.reg_select !== want.reg_select)
            report_mismatch($sformatf("reg_select %b, expected %b",
                                      got.reg_select, want.reg_select));
        if (got.enable_pin !== want.enable_pin)
            report_mismatch($sformatf("enable_pin %b, expected %b",
                                      got.enable_pin, want.enable_pin));
        if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b, expected %b",
                                      got.busy_res, want.busy_res));
        if (got.rejected !== want.rejected)
            report_mismatch($sformatf("rejected %b, expected %b",
                                      got.rejected, want.rejected));
    endtask

    // watch config writes and both channels
    always @(posedge i_clk) begin : watch_channels
        t_res seen;
        t_res predicted;
        if (!i_rst_n) begin
            cfg_two_lines = 1'b0;
            cfg_tall_font = 1'b0;
            cfg_cursor_on = 1'b0;
            cfg_blink = 1'b0;
            cfg_cmd_pulse = CMD_PULSE_RST;
            cfg_dat_pulse = DAT_PULSE_RST;
            seq_step = 5'd0;
            seq_timer = 16'd0;
            seq_op = OP_TICK;
            seq_byte = 8'h00;
            pin_nib = 4'h0;
            pin_rs = 1'b0;
            pin_en = 1'b0;
            lcd_expect_q.delete();
        end else begin
            if (i_cfg_we)
                apply_register(i_cfg_index, i_cfg_data);
            if (i_res_valid && i_res_ready) begin
                seen = {i_data_nibble, i_reg_select, i_enable_pin, i_busy_res, i_rejected};
                compare_result(seen);
            end
            if (i_req_valid && i_req_ready) begin
                step_lcd_bus(t_op'(i_operation), i_value, i_column, i_line, predicted);
                lcd_expect_q.push_back(predicted);
            end
        end
        o_pending <= lcd_expect_q.size();
        o_seq_busy <= (seq_step != 5'd0);
        o_fail_count <= err_total;
    end

endmodule

[test/char_lcd_nibble_interface_sequencer_test.sv]
module char_lcd_nibble_interface_sequencer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import clcd_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_ITEMS    = 500;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_idx   = REG_TWO_LINES;
    logic [15:0] cfg_data  = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [2:0]  req_op    = OP_TICK;
    logic [7:0]  req_value = '0;
    logic [4:0]  req_col   = 5'd1;
    logic [1:0]  req_line  = 2'd1;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [3:0]  res_nibble;
    logic        res_rs;
    logic        res_en;
    logic        res_busy;
    logic        res_rejected;

    int          fail_count;
    int          pending;
    logic        seq_busy;
    bit          gaps_on = 1'b1;
    int unsigned quiet_cycles = 0;

    always #HALF_PERIOD clk = ~clk;

    char_lcd_nibble_interface_sequencer u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (req_valid),
        .o_in_ready    (req_ready),
        .i_operation   (req_op),
        .i_value       (req_value),
        .i_column      (req_col),
        .i_line        (req_line),
        .o_out_valid   (res_valid),
        .i_out_ready   (res_ready),
        .o_data_nibble (res_nibble),
        .o_reg_select  (res_rs),
        .o_enable_pin  (res_en),
        .o_busy_res    (res_busy),
        .o_rejected    (res_rejected)
    );

    clcd_sequencer_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_operation   (req_op),
        .i_value       (req_value),
        .i_column      (req_col),
        .i_line        (req_line),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_data_nibble (res_nibble),
        .i_reg_select  (res_rs),
        .i_enable_pin  (res_en),
        .i_busy_res    (res_busy),
        .i_rejected    (res_rejected),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_seq_busy    (seq_busy)
    );

    // hang detection: cycles with no request and no result moving
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("char_lcd_nibble_interface_sequencer_test: errors");
            $finish;
        end
    end

    // result side: random stall before each result
    initial begin : result_sink
        int unsigned stall;
        @(negedge clk);
        forever begin
            stall = gaps_on ? $urandom_range(0, 14) : 0;
            if (stall != 0) begin
                res_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready = 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // entered and left at a falling edge; valid stays up for a back-to-back request
    task automatic push_request(input t_op op, input logic [7:0] val, input logic [4:0] col,
                                input logic [1:0] ln);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        req_op = op;
        req_value = val;
        req_col = col;
        req_line = ln;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // tick until the sequence in flight has ended
    task automatic tick_until_idle(input bit fast);
        bit keep;
        keep = gaps_on;
        if (fast)
            gaps_on = 1'b0;
        while (seq_busy)
            push_request(OP_TICK, 8'($urandom), 5'($urandom), 2'($urandom));
        gaps_on = keep;
    endtask

    task automatic run_request(input t_op op, input logic [7:0] val, input logic [4:0] col,
                               input logic [1:0] ln);
        push_request(op, val, col, ln);
        tick_until_idle(1'b1);
    endtask

    // stop sending and wait for every owed result
    task automatic settle_block();
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // write all six registers on consecutive cycles
    task automatic load_settings(input logic [3:0] flags, input logic [15:0] cmd_w,
                                 input logic [15:0] dat_w);
        cfg_we = 1'b1;
        cfg_idx = REG_TWO_LINES;
        cfg_data = {15'd0, flags[3]};
        @(negedge clk);
        cfg_idx = REG_TALL_FONT;
        cfg_data = {15'd0, flags[2]};
        @(negedge clk);
        cfg_idx = REG_CURSOR_ON;
        cfg_data = {15'd0, flags[1]};
        @(negedge clk);
        cfg_idx = REG_BLINK;
        cfg_data = {15'd0, flags[0]};
        @(negedge clk);
        cfg_idx = REG_CMD_PULSE;
        cfg_data = cmd_w;
        @(negedge clk);
        cfg_idx = REG_DAT_PULSE;
        cfg_data = dat_w;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial begin : stimulus
        int          taken;
        int unsigned roll;
        bit          busy;
        t_op         op;
        logic [7:0]  val;
        logic [4:0]  col;
        logic [1:0]  ln;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: idle tick, command nibble, refused requests while busy
        push_request(OP_TICK, 8'hFF, 5'd31, 2'd3);
        push_request(OP_CMD, 8'hA5, 5'd0, 2'd0);
        push_request(OP_CHAR, 8'h41, 5'd1, 2'd1);
        push_request(OP_RSVD, 8'h00, 5'd1, 2'd1);
        push_request(OP_INIT, 8'hFF, 5'd16, 2'd2);
        tick_until_idle(1'b1);
        run_request(OP_CHAR, 8'h41, 5'd1, 2'd1);
        settle_block();

        // mixed flags, zero command width, one-tick data width
        load_settings(4'hA, 16'd0, 16'd1);
        run_request(OP_INIT, 8'h00, 5'd1, 2'd1);
        run_request(OP_CMD, 8'hFF, 5'd1, 2'd1);
        run_request(OP_CHAR, 8'h00, 5'd1, 2'd1);
        run_request(OP_CHAR, 8'hFF, 5'd1, 2'd1);
        run_request(OP_POS, 8'h00, 5'd1, 2'd1);
        run_request(OP_POS, 8'hFF, 5'd16, 2'd2);
        run_request(OP_POS, 8'h00, 5'd0, 2'd1);
        run_request(OP_POS, 8'h00, 5'd17, 2'd1);
        run_request(OP_POS, 8'h00, 5'd31, 2'd2);
        run_request(OP_POS, 8'h00, 5'd5, 2'd0);
        run_request(OP_POS, 8'h00, 5'd5, 2'd3);
        run_request(OP_SHIFT, 8'hFF, 5'd1, 2'd1);
        run_request(OP_CGADDR, 8'hFF, 5'd1, 2'd1);
        run_request(OP_CGADDR, 8'h00, 5'd1, 2'd1);
        run_request(OP_RSVD, 8'hFF, 5'd1, 2'd1);
        settle_block();

        // random phases: mostly well-formed requests played out by ticks, plus noise
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_settings(4'($urandom), 16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
            gaps_on = (phase != 1);
            taken = 0;
            while (taken < PHASE_ITEMS) begin
                busy = seq_busy;
                roll = $urandom_range(0, 99);
                val = 8'($urandom);
                col = 5'($urandom);
                ln = 2'($urandom);
                if (busy) begin
                    op = (roll < 80) ? OP_TICK : t_op'($urandom_range(1, 7));
                end else if (roll < 85) begin
                    op = t_op'($urandom_range(2, 6));
                    if (op == OP_POS) begin
                        col = 5'($urandom_range(1, 16));
                        ln = 2'($urandom_range(1, 2));
                    end
                end else if (roll < 90) begin
                    op = OP_RSVD;
                end else if (roll < 95) begin
                    // position out of range
                    op = OP_POS;
                    if ($urandom_range(0, 1)) begin
                        ln = 2'($urandom_range(1, 2));
                        col = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
                    end else begin
                        ln = $urandom_range(0, 1) ? 2'd0 : 2'd3;
                    end
                end else begin
                    op = OP_TICK;
                end
                push_request(op, val, col, ln);
                if (busy || op != OP_TICK)
                    taken++;
            end
            tick_until_idle(1'b0);
            settle_block();
        end
        gaps_on = 1'b1;

        if (fail_count == 0 && pending == 0)
            $display("char_lcd_nibble_interface_sequencer_test: clean");
        else
            $display("char_lcd_nibble_interface_sequencer_test: errors");
        $finish;
    end

endmodule
